@@ rtl/apq_pkg.sv @@
// ============================================================================
// apq_pkg
// Shared types and constants of the age priority queue.
// ============================================================================
package apq_pkg;

  localparam int CAPACITY = 16;
  localparam int KEY_BITS = 16;
  localparam int AGE_BITS = 8;

  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 3;

  localparam int IN_FIELDS_W  = CMD_W + KEY_BITS + AGE_BITS;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = STATUS_W + KEY_BITS + AGE_BITS + CNT_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam int IN_KEY_LSB  = CMD_W;
  localparam int IN_AGE_LSB  = CMD_W + KEY_BITS;
  localparam int OUT_KEY_LSB = STATUS_W;
  localparam int OUT_AGE_LSB = STATUS_W + KEY_BITS;
  localparam int OUT_CNT_LSB = STATUS_W + KEY_BITS + AGE_BITS;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT     = 2'd0,
    CMD_POP_PRIO   = 2'd1,
    CMD_POP_OLDEST = 2'd2,
    CMD_QUERY      = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK      = 3'd0,
    STAT_DUP     = 3'd1,
    STAT_FULL    = 3'd2,
    STAT_EMPTY   = 3'd3,
    STAT_MISSING = 3'd4
  } status_t;

  typedef struct packed {
    logic clear;
    logic step;
    logic prio;
  } scan_ctl_t;

  typedef struct packed {
    logic                valid;
    logic [KEY_BITS-1:0] key;
    logic [AGE_BITS-1:0] age;
    logic [IDX_W-1:0]    rank;
  } slot_view_t;

  typedef struct packed {
    logic                match_found;
    logic [AGE_BITS-1:0] match_age;
    logic                free_found;
    logic [IDX_W-1:0]    free_idx;
    logic                best_found;
    logic [IDX_W-1:0]    best_idx;
    logic [KEY_BITS-1:0] best_key;
    logic [AGE_BITS-1:0] best_age;
    logic [IDX_W-1:0]    best_rank;
  } scan_res_t;

endpackage

@@ rtl/age_priority_queue_with_fifo.sv @@
// ============================================================================
// age_priority_queue_with_fifo
// Bounded table of keyed entries served in priority order or arrival order.
// ============================================================================
// Channel  Direction  Handshake             Contents
// in_      request    in_tvalid/in_tready   command, entry_key, entry_age
// out_     result     out_tvalid/out_tready status, out_key, out_age, count
//
// A request is accepted while idle; the shared compare unit then examines one
// slot per cycle across all sixteen slots, and a commit step applies the change.
// The commit waits while the previous result has not yet been taken.
// Reset clears the slot valid bits and the entry count.
// ============================================================================
module age_priority_queue_with_fifo
  import apq_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [1:0] command, [17:2] entry_key, [25:18] entry_age, upper bits zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [2:0] status, [18:3] out_key, [26:19] out_age, [31:27] count
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_COMMIT = 3'b100
  } state_t;

  state_t              state_r;
  logic [IDX_W-1:0]    idx_r;
  cmd_t                cmd_r;
  logic [KEY_BITS-1:0] qkey_r;
  logic [AGE_BITS-1:0] qage_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [CNT_W-1:0]    cnt_nxt;
  logic [CAPACITY-1:0] valid_r;

  logic [KEY_BITS-1:0] skey_r  [CAPACITY];
  logic [AGE_BITS-1:0] sage_r  [CAPACITY];
  logic [IDX_W-1:0]    srank_r [CAPACITY];

  logic                out_valid_r;
  status_t             out_status_r;
  logic [KEY_BITS-1:0] out_key_r;
  logic [AGE_BITS-1:0] out_age_r;
  logic [CNT_W-1:0]    out_count_r;

  scan_ctl_t  sctl;
  slot_view_t sview;
  scan_res_t  sres;

  logic                in_fire;
  logic                commit_go;
  logic                do_insert;
  logic                do_remove;
  status_t             stat;
  logic [KEY_BITS-1:0] okey;
  logic [AGE_BITS-1:0] oage;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign commit_go = (state_r == S_COMMIT) && (!out_valid_r || out_tready);

  assign sctl.clear = in_fire;
  assign sctl.step  = (state_r == S_SCAN);
  assign sctl.prio  = (cmd_r == CMD_POP_PRIO);

  assign sview.valid = valid_r[idx_r];
  assign sview.key   = skey_r[idx_r];
  assign sview.age   = sage_r[idx_r];
  assign sview.rank  = srank_r[idx_r];

  apq_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (sctl),
    .idx       (idx_r),
    .query_key (qkey_r),
    .slot      (sview),
    .res       (sres)
  );

  always_comb begin
    stat      = STAT_OK;
    okey      = '0;
    oage      = '0;
    cnt_nxt   = cnt_r;
    do_insert = 1'b0;
    do_remove = 1'b0;
    unique case (cmd_r)
      CMD_INSERT: begin
        priority if (sres.match_found) begin
          stat = STAT_DUP;
        end else if (cnt_r == CNT_W'(CAPACITY) || !sres.free_found) begin
          stat = STAT_FULL;
        end else begin
          do_insert = 1'b1;
          cnt_nxt   = cnt_r + CNT_W'(1);
        end
      end
      CMD_POP_PRIO, CMD_POP_OLDEST: begin
        if (!sres.best_found) begin
          stat = STAT_EMPTY;
        end else begin
          do_remove = 1'b1;
          okey      = sres.best_key;
          oage      = sres.best_age;
          cnt_nxt   = cnt_r - CNT_W'(1);
        end
      end
      CMD_QUERY: begin
        if (sres.match_found) begin
          oage = sres.match_age;
        end else begin
          stat = STAT_MISSING;
        end
      end
      default: begin
        stat = STAT_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            state_r <= S_SCAN;
            idx_r   <= '0;
          end
        end
        S_SCAN: begin
          idx_r <= idx_r + IDX_W'(1);
          if (idx_r == IDX_W'(CAPACITY - 1)) begin
            state_r <= S_COMMIT;
          end
        end
        S_COMMIT: begin
          if (commit_go) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r  <= cmd_t'(in_tdata[CMD_W-1:0]);
      qkey_r <= in_tdata[IN_KEY_LSB +: KEY_BITS];
      qage_r <= in_tdata[IN_AGE_LSB +: AGE_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      cnt_r   <= '0;
    end else if (commit_go) begin
      cnt_r <= cnt_nxt;
      if (do_insert) begin
        valid_r[sres.free_idx] <= 1'b1;
      end
      if (do_remove) begin
        valid_r[sres.best_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit_go && do_insert) begin
      skey_r[sres.free_idx] <= qkey_r;
      sage_r[sres.free_idx] <= qage_r;
    end
    for (int i = 0; i < CAPACITY; i++) begin
      if (commit_go && do_insert && (sres.free_idx == IDX_W'(i))) begin
        srank_r[i] <= cnt_r[IDX_W-1:0];
      end else if (commit_go && do_remove && valid_r[i] &&
                   (srank_r[i] > sres.best_rank)) begin
        srank_r[i] <= srank_r[i] - IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit_go) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit_go) begin
      out_status_r <= stat;
      out_key_r    <= okey;
      out_age_r    <= oage;
      out_count_r  <= cnt_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

  always_comb begin
    out_tdata                            = '0;
    out_tdata[STATUS_W-1:0]              = out_status_r;
    out_tdata[OUT_KEY_LSB +: KEY_BITS]   = out_key_r;
    out_tdata[OUT_AGE_LSB +: AGE_BITS]   = out_age_r;
    out_tdata[OUT_CNT_LSB +: CNT_W]      = out_count_r;
  end

  // The count always matches the number of occupied slots.
  a_count_matches_valid : assert property (
    @(posedge clk) disable iff (!rst_n)
      CNT_W'($countones(valid_r)) == cnt_r
  ) else $error("entry count disagrees with occupied slots");

  // The count never exceeds the table size.
  a_count_bounded : assert property (
    @(posedge clk) disable iff (!rst_n)
      cnt_r <= CNT_W'(CAPACITY)
  ) else $error("entry count above capacity");

  // An accepted request always starts a scan at the first slot.
  a_scan_starts : assert property (
    @(posedge clk) disable iff (!rst_n)
      in_fire |=> (state_r == S_SCAN) && (idx_r == '0)
  ) else $error("scan did not start after request");

  // A successful removal lowers the count by one.
  a_remove_count : assert property (
    @(posedge clk) disable iff (!rst_n)
      (commit_go && do_remove) |=> cnt_r == $past(cnt_r) - CNT_W'(1)
  ) else $error("removal did not lower the count");

endmodule

@@ rtl/apq_scan.sv @@
// ============================================================================
// apq_scan
// Shared compare unit that looks at one slot per cycle and keeps the running
// key match, first free slot and best candidate for removal.
// ============================================================================
module apq_scan
  import apq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  scan_ctl_t  ctl,
  input  logic [IDX_W-1:0]    idx,
  input  logic [KEY_BITS-1:0] query_key,
  input  slot_view_t slot,
  output scan_res_t  res
);

  scan_res_t res_r;
  logic      take_best;
  logic      better;
  logic      key_hit;

  always_comb begin
    if (ctl.prio) begin
      better = (slot.age > res_r.best_age) ||
               ((slot.age == res_r.best_age) && (slot.rank < res_r.best_rank));
    end else begin
      better = slot.rank < res_r.best_rank;
    end
    take_best = slot.valid && (!res_r.best_found || better);
    key_hit   = slot.valid && (slot.key == query_key) && !res_r.match_found;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r.match_found <= 1'b0;
      res_r.free_found  <= 1'b0;
      res_r.best_found  <= 1'b0;
    end else if (ctl.clear) begin
      res_r.match_found <= 1'b0;
      res_r.free_found  <= 1'b0;
      res_r.best_found  <= 1'b0;
    end else if (ctl.step) begin
      if (key_hit) begin
        res_r.match_found <= 1'b1;
        res_r.match_age   <= slot.age;
      end
      if (!slot.valid && !res_r.free_found) begin
        res_r.free_found <= 1'b1;
        res_r.free_idx   <= idx;
      end
      if (take_best) begin
        res_r.best_found <= 1'b1;
        res_r.best_idx   <= idx;
        res_r.best_key   <= slot.key;
        res_r.best_age   <= slot.age;
        res_r.best_rank  <= slot.rank;
      end
    end
  end

  assign res = res_r;

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Self-checking bench for the age priority queue with FIFO removal.
// A directed table covers the empty, full and duplicate cases and the extreme
// keys and ages. Random requests follow in four phases with different amounts
// of sender idling and receiver stalling. Every result is compared field by
// field, against the row's expected result where the table gives one and
// otherwise against a behavioural model of the table kept alongside the design.
// ============================================================================
module tb_top;
  import apq_pkg::*;

  typedef struct packed {
    status_t             status;
    logic [KEY_BITS-1:0] key;
    logic [AGE_BITS-1:0] age;
    logic [CNT_W-1:0]    count;
  } apq_result_t;

  typedef struct {
    cmd_t                cmd;
    logic [KEY_BITS-1:0] key;
    logic [AGE_BITS-1:0] age;
    bit                  typed;
    apq_result_t         want;
  } req_row_t;

  localparam int DIRECTED_ROWS = 25;
  localparam int PHASE_ITEMS   = 225;
  localparam int POOL_SIZE     = 20;
  localparam int HOLD_CYCLES   = 300;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;

  logic                   held_valid [CAPACITY];
  logic [KEY_BITS-1:0]    held_key   [CAPACITY];
  logic [AGE_BITS-1:0]    held_age   [CAPACITY];
  logic [IDX_W-1:0]       held_rank  [CAPACITY];
  logic [CNT_W-1:0]       held_count;

  apq_result_t            pending_results [$];
  int                     errors = 0;
  int                     sender_idle_pct = 0;
  int                     receiver_stall_pct = 0;
  int                     hold_requests = 0;

  req_row_t directed_rows [DIRECTED_ROWS] = '{
    '{CMD_QUERY,      16'h0000, 8'h00, 1'b1, '{STAT_MISSING, 16'h0000, 8'h00, 5'd0}},
    '{CMD_POP_PRIO,   16'hFFFF, 8'hFF, 1'b1, '{STAT_EMPTY,   16'h0000, 8'h00, 5'd0}},
    '{CMD_POP_OLDEST, 16'hFFFF, 8'hFF, 1'b1, '{STAT_EMPTY,   16'h0000, 8'h00, 5'd0}},
    '{CMD_INSERT,     16'hFFFF, 8'hFF, 1'b1, '{STAT_OK,      16'h0000, 8'h00, 5'd1}},
    '{CMD_INSERT,     16'hFFFF, 8'h00, 1'b1, '{STAT_DUP,     16'h0000, 8'h00, 5'd1}},
    '{CMD_QUERY,      16'hFFFF, 8'h00, 1'b1, '{STAT_OK,      16'h0000, 8'hFF, 5'd1}},
    '{CMD_INSERT,     16'h0000, 8'h00, 1'b1, '{STAT_OK,      16'h0000, 8'h00, 5'd2}},
    '{CMD_INSERT,     16'h0001, 8'h80, 1'b0, '{STAT_OK, 16'h0, 8'h0, 5'd0}},
    '{CMD_INSERT,     16'h8000, 8'h80, 1'b0, '{STAT_OK, 16'h0, 8'h0, 5'd0}},
    '{CMD_INSERT,     16'h5555, 8'h01, 1'b0, '{STAT_OK, 16'h0, 8'h0, 5'd0}},
    '{CMD_INSERT,     16'hAAAA, 8'hFE, 1'b0, '{STAT_OK, 16'h0, 8'h0, 5'd0}},
    '{CMD_INSERT,     16'h0002, 8'h80, 1'b0, '{STAT_OK, 16'h0, 8'h0, 5'd0}},
    '{CMD_INSERT,     16'h0003, 8'h7F, 1'b0, '{STAT_OK, 16'h0, 8'h0, 5'd0}},
    '{CMD_INSERT,     16'h0004, 8'hFE, 1'b0, '{STAT_OK, 16'h0, 8'h0, 5'd0}},
    '{CMD_INSERT,     16'h1234, 8'h55, 1'b0, '{STAT_OK, 16'h0, 8'h0, 5'd0}},
    '{CMD_INSERT,     16'hFFFE, 8'hAA, 1'b0, '{STAT_OK, 16'h0, 8'h0, 5'd0}},
    '{CMD_INSERT,     16'h00FF, 8'h00, 1'b0, '{STAT_OK, 16'h0, 8'h0, 5'd0}},
    '{CMD_INSERT,     16'hFF00, 8'h10, 1'b0, '{STAT_OK, 16'h0, 8'h0, 5'd0}},
    '{CMD_INSERT,     16'h0F0F, 8'h80, 1'b0, '{STAT_OK, 16'h0, 8'h0, 5'd0}},
    '{CMD_INSERT,     16'hF0F0, 8'h01, 1'b0, '{STAT_OK, 16'h0, 8'h0, 5'd0}},
    '{CMD_INSERT,     16'h7FFF, 8'hFE, 1'b0, '{STAT_OK, 16'h0, 8'h0, 5'd0}},
    '{CMD_INSERT,     16'h4000, 8'h33, 1'b1, '{STAT_FULL,    16'h0000, 8'h00, 5'd16}},
    '{CMD_INSERT,     16'hFFFF, 8'h33, 1'b1, '{STAT_DUP,     16'h0000, 8'h00, 5'd16}},
    '{CMD_POP_PRIO,   16'h0000, 8'h00, 1'b1, '{STAT_OK,      16'hFFFF, 8'hFF, 5'd15}},
    '{CMD_POP_OLDEST, 16'h0000, 8'h00, 1'b1, '{STAT_OK,      16'h0000, 8'h00, 5'd14}}
  };

  age_priority_queue_with_fifo dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  initial begin
    #3_000_000;
    $display("tb_top: errors");
    $finish;
  end

  function automatic int slot_of_key(logic [KEY_BITS-1:0] key);
    for (int i = 0; i < CAPACITY; i++) begin
      if (held_valid[i] && held_key[i] == key) return i;
    end
    return -1;
  endfunction

  // Applies one request to the table copy and returns the result it gives.
  function automatic apq_result_t apply_request(cmd_t cmd, logic [KEY_BITS-1:0] key,
                                                logic [AGE_BITS-1:0] age);
    apq_result_t      res;
    int               s;
    logic [IDX_W-1:0] gone;
    res.status = STAT_OK;
    res.key    = '0;
    res.age    = '0;
    s          = -1;
    case (cmd)
      CMD_INSERT: begin
        if (slot_of_key(key) >= 0) begin
          res.status = STAT_DUP;
        end else if (held_count >= CAPACITY) begin
          res.status = STAT_FULL;
        end else begin
          for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (!held_valid[i]) s = i;
          end
          held_valid[s] = 1'b1;
          held_key[s]   = key;
          held_age[s]   = age;
          held_rank[s]  = held_count[IDX_W-1:0];
          held_count    = held_count + 1'b1;
        end
      end
      CMD_POP_PRIO, CMD_POP_OLDEST: begin
        for (int i = 0; i < CAPACITY; i++) begin
          if (!held_valid[i]) continue;
          if (s < 0) begin
            s = i;
          end else if (cmd == CMD_POP_OLDEST) begin
            if (held_rank[i] < held_rank[s]) s = i;
          end else if (held_age[i] > held_age[s] ||
                       (held_age[i] == held_age[s] && held_rank[i] < held_rank[s])) begin
            s = i;
          end
        end
        if (s < 0) begin
          res.status = STAT_EMPTY;
        end else begin
          res.key       = held_key[s];
          res.age       = held_age[s];
          gone          = held_rank[s];
          held_valid[s] = 1'b0;
          for (int i = 0; i < CAPACITY; i++) begin
            if (held_valid[i] && held_rank[i] > gone) held_rank[i] = held_rank[i] - 1'b1;
          end
          held_count = held_count - 1'b1;
        end
      end
      default: begin
        s = slot_of_key(key);
        if (s < 0) res.status = STAT_MISSING;
        else res.age = held_age[s];
      end
    endcase
    res.count = held_count;
    return res;
  endfunction

  task automatic send_request(cmd_t cmd, logic [KEY_BITS-1:0] key, logic [AGE_BITS-1:0] age,
                              bit typed, apq_result_t want);
    logic [IN_TDATA_W-1:0] word;
    apq_result_t           modelled;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    word = '0;
    word[CMD_W-1:0]                 = cmd;
    word[IN_KEY_LSB +: KEY_BITS]    = key;
    word[IN_AGE_LSB +: AGE_BITS]    = age;
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    modelled = apply_request(cmd, key, age);
    pending_results.push_back(typed ? want : modelled);
    @(negedge clk);
  endtask

  initial begin
    int hold_done;
    int hold_left;
    hold_done  = 0;
    hold_left  = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_requests != hold_done) begin
        hold_done = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= receiver_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    apq_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result %h with nothing outstanding", out_tdata);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[STATUS_W-1:0] !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_tdata[STATUS_W-1:0]);
          errors++;
        end
        if (out_tdata[OUT_KEY_LSB +: KEY_BITS] !== want.key) begin
          $error("out_key: expected %h, got %h", want.key, out_tdata[OUT_KEY_LSB +: KEY_BITS]);
          errors++;
        end
        if (out_tdata[OUT_AGE_LSB +: AGE_BITS] !== want.age) begin
          $error("out_age: expected %h, got %h", want.age, out_tdata[OUT_AGE_LSB +: AGE_BITS]);
          errors++;
        end
        if (out_tdata[OUT_CNT_LSB +: CNT_W] !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, out_tdata[OUT_CNT_LSB +: CNT_W]);
          errors++;
        end
      end
    end
  end

  initial begin
    int                  idle_pct [4];
    int                  stall_pct [4];
    logic [KEY_BITS-1:0] key_pool [POOL_SIZE];
    bit                  filling;
    int                  pick;
    cmd_t                cmd;
    logic [KEY_BITS-1:0] key;
    logic [AGE_BITS-1:0] age;
    idle_pct  = '{0, 66, 0, 26};
    stall_pct = '{0, 0, 66, 26};
    filling   = 1'b1;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    for (int i = 0; i < CAPACITY; i++) held_valid[i] = 1'b0;
    held_count = '0;
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = KEY_BITS'($urandom_range(16'hFFFF));
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].cmd, directed_rows[i].key, directed_rows[i].age,
                   directed_rows[i].typed, directed_rows[i].want);
    end

    for (int ph = 0; ph < 4; ph++) begin
      sender_idle_pct    = idle_pct[ph];
      receiver_stall_pct = stall_pct[ph];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 0 && n == 100) hold_requests++;
        if (ph == 2 && n == 110) begin
          in_tvalid <= 1'b0;
          while (pending_results.size() != 0) @(negedge clk);
        end
        if (n % 30 == 0) filling = $urandom_range(1);
        pick = $urandom_range(99);
        if (filling) begin
          if (pick < 55) cmd = CMD_INSERT;
          else if (pick < 70) cmd = CMD_POP_PRIO;
          else if (pick < 85) cmd = CMD_POP_OLDEST;
          else cmd = CMD_QUERY;
        end else begin
          if (pick < 20) cmd = CMD_INSERT;
          else if (pick < 50) cmd = CMD_POP_PRIO;
          else if (pick < 80) cmd = CMD_POP_OLDEST;
          else cmd = CMD_QUERY;
        end
        if ($urandom_range(99) < 85) key = key_pool[$urandom_range(POOL_SIZE - 1)];
        else key = KEY_BITS'($urandom_range(16'hFFFF));
        if ($urandom_range(99) < 60) age = AGE_BITS'($urandom_range(255));
        else age = AGE_BITS'($urandom_range(3));
        send_request(cmd, key, age, 1'b0, '0);
      end
    end

    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/apq_pkg.sv
rtl/apq_scan.sv
rtl/age_priority_queue_with_fifo.sv
test/tb_top.sv
